### src/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

   // Field widths
   localparam int KEY_W        = 32;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 5;
   localparam int CAPACITY_DEF = 16;

   // Operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // Request payload
   typedef struct packed {
      op_type                    op;
      logic signed [KEY_W-1:0]   entry_key;
      logic signed [VALUE_W-1:0] entry_value;
   } req_type;

   // Response payload
   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] found_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      overflow;
   } rsp_type;

   // Per-cycle commands broadcast to every cell
   typedef struct packed {
      logic compare;   // latch key compare flags
      logic insert;    // open a slot and place the new pair
      logic shift;     // close one gap left of the removed key
      logic clear;     // drop every pair
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Keeps up to CAPACITY key/value pairs in ascending signed key order in a row
// of cells; supports insert, find, remove-all and clear.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction   Payload
//   request   req_valid, req_stall, req_data in          skvt_pkg::req_type
//   response  rsp_valid, rsp_stall, rsp_data out         skvt_pkg::rsp_type
//
// Insert, find and clear: the cells latch their compare flags on the
// accepting edge and act in ST_ACT, which waits for a free response slot.
// Remove-all passes through ST_CMP and ST_ACT for each of M matching pairs:
// each pass through the cell row recompares and closes one gap.
// Reset empties the table at once (valid bit per cell); no clearing pass.
// A request may be accepted while a response waits; its last step holds until
// the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_core #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire skvt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output skvt_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_ACT  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   skvt_pkg::req_type      req_ff;
   skvt_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_valid_ff;
   logic [CNT_W-1:0]       count_ff, count_in;

   skvt_pkg::cell_ctl_type ctl;
   logic [skvt_pkg::KEY_W-1:0]   cmp_key;
   logic [skvt_pkg::KEY_W-1:0]   key_vec   [CAPACITY];
   logic [skvt_pkg::VALUE_W-1:0] value_vec [CAPACITY];
   logic [CAPACITY-1:0]          valid_vec;
   logic [CAPACITY-1:0]          eq_vec;
   logic [CAPACITY-1:0]          ins_vec;
   logic [CAPACITY-1:0]          first_vec;
   logic [skvt_pkg::VALUE_W-1:0] hit_value;

   logic accept;
   logic any_eq;
   logic full;
   logic slot_free;
   logic last_step;
   logic act_en;
   logic rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Hold the request for the remainder of the operation
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Compare against the port on accept, against the held key afterwards
   assign cmp_key = (state_ff == ST_IDLE) ? req_data.entry_key : req_ff.entry_key;

   assign any_eq    = |eq_vec;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_step = !((req_ff.op == skvt_pkg::OP_REMOVE) && any_eq);
   assign act_en    = (state_ff == ST_ACT) && (!last_step || slot_free);
   assign rsp_load  = act_en && last_step;

   // Broadcast commands to the cells
   always_comb begin
      ctl.compare = accept || (state_ff == ST_CMP);
      ctl.insert  = act_en && (req_ff.op == skvt_pkg::OP_INSERT) && !full;
      ctl.shift   = act_en && (req_ff.op == skvt_pkg::OP_REMOVE) && any_eq;
      ctl.clear   = act_en && (req_ff.op == skvt_pkg::OP_CLEAR);
   end

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [skvt_pkg::KEY_W-1:0]   p_key;
      logic [skvt_pkg::VALUE_W-1:0] p_value;
      logic                         p_valid;
      logic                         p_ins;
      logic [skvt_pkg::KEY_W-1:0]   n_key;
      logic [skvt_pkg::VALUE_W-1:0] n_value;
      logic                         n_valid;

      if (i == 0) begin : g_head
         assign p_key   = req_ff.entry_key;
         assign p_value = req_ff.entry_value;
         assign p_valid = 1'b0;
         assign p_ins   = 1'b0;
      end else begin : g_body
         assign p_key   = key_vec[i-1];
         assign p_value = value_vec[i-1];
         assign p_valid = valid_vec[i-1];
         assign p_ins   = ins_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_key   = req_ff.entry_key;
         assign n_value = req_ff.entry_value;
         assign n_valid = 1'b0;
      end else begin : g_inner
         assign n_key   = key_vec[i+1];
         assign n_value = value_vec[i+1];
         assign n_valid = valid_vec[i+1];
      end

      skvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cmp_key    (cmp_key),
         .new_key    (req_ff.entry_key),
         .new_value  (req_ff.entry_value),
         .prev_key   (p_key),
         .prev_value (p_value),
         .prev_valid (p_valid),
         .prev_ins   (p_ins),
         .next_key   (n_key),
         .next_value (n_value),
         .next_valid (n_valid),
         .key        (key_vec[i]),
         .value      (value_vec[i]),
         .valid      (valid_vec[i]),
         .eq         (eq_vec[i]),
         .ins        (ins_vec[i])
      );
   end

   // Select the first matching cell; matches are contiguous in sorted order
   assign first_vec = eq_vec & ~(eq_vec << 1);

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_vec[i]) begin
            hit_value = hit_value | value_vec[i];
         end
      end
   end

   // Advance the entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Sequence: accept, act, and loop back to compare while removing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACT;
            end
         end
         ST_CMP: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            if (act_en) begin
               state_in = last_step ? ST_IDLE : ST_CMP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Build the response
   always_comb begin
      rsp_in.found       = (req_ff.op == skvt_pkg::OP_FIND) && any_eq;
      rsp_in.found_value = rsp_in.found ? hit_value : '0;
      rsp_in.entry_count = skvt_pkg::COUNT_W'(count_in);
      rsp_in.overflow    = (req_ff.op == skvt_pkg::OP_INSERT) && full;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count disagrees with occupied cells");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (act_en && (req_ff.op == skvt_pkg::OP_INSERT) && full) |=>
         (count_ff == $past(count_ff)) && (valid_vec == $past(valid_vec)))
      else $error("insert into full table changed contents");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("response overwritten before it was taken");
`endif

endmodule

`default_nettype wire

### src/skvt_cell.sv
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted table: holds a key/value pair, compares it with the
// request key and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cell (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire skvt_pkg::cell_ctl_type         ctl,
   input  wire  [skvt_pkg::KEY_W-1:0]          cmp_key,
   input  wire  [skvt_pkg::KEY_W-1:0]          new_key,
   input  wire  [skvt_pkg::VALUE_W-1:0]        new_value,
   input  wire  [skvt_pkg::KEY_W-1:0]          prev_key,
   input  wire  [skvt_pkg::VALUE_W-1:0]        prev_value,
   input  wire                                 prev_valid,
   input  wire                                 prev_ins,
   input  wire  [skvt_pkg::KEY_W-1:0]          next_key,
   input  wire  [skvt_pkg::VALUE_W-1:0]        next_value,
   input  wire                                 next_valid,
   output logic [skvt_pkg::KEY_W-1:0]          key,
   output logic [skvt_pkg::VALUE_W-1:0]        value,
   output logic                                valid,
   output logic                                eq,
   output logic                                ins
);

   logic [skvt_pkg::KEY_W-1:0]   key_ff;
   logic [skvt_pkg::VALUE_W-1:0] value_ff;
   logic                         valid_ff;
   logic                         eq_ff;
   logic                         gt_ff;
   logic                         eq_in;
   logic                         gt_in;
   logic                         ge;

   // Compare stored key with the request key, signed order
   assign eq_in = valid_ff && (key_ff == cmp_key);
   assign gt_in = valid_ff && ($signed(key_ff) > $signed(cmp_key));

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_ff <= 1'b0;
         gt_ff <= 1'b0;
      end else if (ctl.compare) begin
         eq_ff <= eq_in;
         gt_ff <= gt_in;
      end
   end

   // Hold flag state for the neighbors
   assign eq  = eq_ff;
   assign ge  = eq_ff || gt_ff;
   assign ins = !valid_ff || gt_ff;

   // Valid bit: clear, take new pair, take left or right neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.insert && ins) begin
         valid_ff <= prev_ins ? prev_valid : 1'b1;
      end else if (ctl.shift && ge) begin
         valid_ff <= next_valid;
      end
   end

   // Payload moves with the valid bit
   always_ff @(posedge clock) begin
      if (ctl.insert && ins) begin
         if (prev_ins) begin
            key_ff   <= prev_key;
            value_ff <= prev_value;
         end else begin
            key_ff   <= new_key;
            value_ff <= new_value;
         end
      end else if (ctl.shift && ge) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

### verif/sorted_key_value_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_core_tb
// Self-checking bench for the sorted key/value table. A short table of
// directed requests covers the field extremes, duplicate keys, removal of
// absent and repeated keys, the full-table drop and clear. About a thousand
// random requests follow, drawn mostly from a small key pool so that finds
// hit, removals delete runs and the table fills. A behavioral model of the
// table predicts every response, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_core_tb;
   import skvt_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_COUNT = 1000;
   localparam int DRAIN_CYCLES = 2 + 2 * CAPACITY + 8;

   typedef struct {
      req_type request;
      bit      typed;
      rsp_type result;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Table model state
   logic signed [KEY_W-1:0]   key_store [CAPACITY];
   logic signed [VALUE_W-1:0] value_store [CAPACITY];
   int                        pair_count = 0;

   rsp_type          pending_results [$];
   directed_row_type directed_rows [$];
   int               mismatch_count = 0;

   sorted_key_value_table_core #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Apply one request to the table model and return its response
   function automatic rsp_type apply_table_op(input req_type r);
      rsp_type res;
      int      pos;
      int      wr;
      res = '0;
      case (r.op)
         OP_INSERT: begin
            if (pair_count >= CAPACITY) begin
               res.overflow = 1'b1;
            end else begin
               // land after every pair with an equal key
               pos = 0;
               while (pos < pair_count && key_store[pos] <= r.entry_key) pos++;
               for (int i = pair_count; i > pos; i--) begin
                  key_store[i]   = key_store[i-1];
                  value_store[i] = value_store[i-1];
               end
               key_store[pos]   = r.entry_key;
               value_store[pos] = r.entry_value;
               pair_count++;
            end
         end
         OP_FIND: begin
            for (int i = 0; i < pair_count; i++) begin
               if (key_store[i] == r.entry_key) begin
                  res.found       = 1'b1;
                  res.found_value = value_store[i];
                  break;
               end
            end
         end
         OP_REMOVE: begin
            // compact the survivors toward the front
            wr = 0;
            for (int i = 0; i < pair_count; i++) begin
               if (key_store[i] != r.entry_key) begin
                  key_store[wr]   = key_store[i];
                  value_store[wr] = value_store[i];
                  wr++;
               end
            end
            pair_count = wr;
         end
         default: begin
            pair_count = 0;
         end
      endcase
      res.entry_count = COUNT_W'(pair_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   // Mostly short idle stretches, now and then a long one
   function automatic int draw_idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // Small pool of keys so that finds and removals hit stored pairs
   function automatic logic [KEY_W-1:0] pool_key(input int idx);
      case (idx)
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         4: return 32'h7FFF_FFFF;
         5: return 32'hFFFF_FFF9;
         6: return 32'h0000_002A;
         default: return 32'h0001_0000;
      endcase
   endfunction

   task automatic add_row(input op_type op, input logic [KEY_W-1:0] k,
                          input logic [VALUE_W-1:0] v, input bit typed,
                          input logic [COUNT_W-1:0] cnt, input logic ovf);
      directed_row_type row;
      row.request.op          = op;
      row.request.entry_key   = k;
      row.request.entry_value = v;
      row.typed               = typed;
      row.result              = '0;
      row.result.entry_count  = cnt;
      row.result.overflow     = ovf;
      directed_rows.push_back(row);
   endtask

   // Present one request, hold it until accepted, then log its expected response
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_res);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = apply_table_op(r);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // Response stall: quiet stretches mixed with random stalls
   initial begin
      int quiet;
      int hold;
      forever begin
         quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         rsp_stall <= 1'b0;
         repeat (quiet) @(posedge clock);
         hold = draw_idle_cycles() + 1;
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
      end
   end

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", 64'd0, 64'(rsp_data));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", 64'(want.found), 64'(rsp_data.found));
            if (rsp_data.found_value !== want.found_value)
               report_mismatch("found_value", 64'(want.found_value),
                               64'(rsp_data.found_value));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", 64'(want.entry_count),
                               64'(rsp_data.entry_count));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", 64'(want.overflow), 64'(rsp_data.overflow));
         end
      end
   end

   // Stimulus
   initial begin
      req_type r;
      int      gap;
      int      pick;
      int      phase;

      // Directed rows: empty table, extremes, duplicates, fill, drop, clear
      add_row(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 5'd0, 1'b0);
      add_row(OP_REMOVE, 32'h0000_007B, 32'h0000_0000, 1'b1, 5'd0, 1'b0);
      add_row(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 5'd0, 1'b0);
      add_row(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd0, 1'b0);
      add_row(OP_INSERT, 32'h0000_0000, 32'h0000_0001, 1'b0, 5'd0, 1'b0);
      add_row(OP_INSERT, 32'h0000_0000, 32'h0000_0002, 1'b0, 5'd0, 1'b0);
      add_row(OP_FIND,   32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 5'd0, 1'b0);
      add_row(OP_FIND,   32'h8000_0000, 32'h0000_0000, 1'b0, 5'd0, 1'b0);
      add_row(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0);
      for (int i = 0; i < CAPACITY - 2; i++)
         add_row(OP_INSERT, 32'(i % 5) - 32'd2, 32'(i), 1'b0, 5'd0, 1'b0);
      add_row(OP_INSERT, 32'h0000_0000, 32'h5555_5555, 1'b1, 5'(CAPACITY), 1'b1);
      add_row(OP_FIND,   32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 5'd0, 1'b0);
      add_row(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         gap = draw_idle_cycles();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_request(directed_rows[i].request, directed_rows[i].typed,
                      directed_rows[i].result);
      end

      // Random requests in phases: balanced, fill-heavy, remove-heavy
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         phase = (n / 100) % 3;
         pick  = $urandom_range(0, 99);
         case (phase)
            0: r.op = (pick < 45) ? OP_INSERT : (pick < 75) ? OP_FIND :
                      (pick < 96) ? OP_REMOVE : OP_CLEAR;
            1: r.op = (pick < 70) ? OP_INSERT : (pick < 90) ? OP_FIND :
                      (pick < 99) ? OP_REMOVE : OP_CLEAR;
            default: r.op = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_FIND :
                            (pick < 95) ? OP_REMOVE : OP_CLEAR;
         endcase
         r.entry_key   = ($urandom_range(0, 3) == 0) ? $urandom() :
                         pool_key($urandom_range(0, 7));
         r.entry_value = $urandom();
         // back-to-back stretches at the start of every 200 requests
         gap = ((n % 200) < 50) ? 0 : draw_idle_cycles();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_request(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain, then allow the longest remove-all to finish
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
src/skvt_pkg.sv
src/skvt_cell.sv
src/sorted_key_value_table_core.sv
verif/sorted_key_value_table_core_tb.sv
